// ===== sv/assert_macros.svh =====
// Assertion macros shared by the decoder RTL.
// Clocked on clk, disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/utf8d_pkg.sv =====
// Types and constants for the UTF-8 stream decoder.
// No dependencies.
`timescale 1ns / 1ps

package utf8d_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_CONT   = 2'd1,
    ST_BAD_LEADER = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]      bytes_left;
    logic [CP_W-1:0] accumulator;
    logic            bad_cont;
  } dec_state_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    status_t         status;
    logic            is_term;
  } result_t;

endpackage

// ===== sv/utf8d_step.sv =====
// Per-byte decode step: next decoder state and optional result.
// Depends on utf8d_pkg.
`timescale 1ns / 1ps

module utf8d_step (
  input  logic [utf8d_pkg::BYTE_W-1:0] byte_in,
  input  utf8d_pkg::dec_state_t        state,
  output utf8d_pkg::dec_state_t        state_next,
  output logic                         emit,
  output utf8d_pkg::result_t           result
);
  import utf8d_pkg::*;

  logic [1:0] left_dec;

  assign left_dec = state.bytes_left - 2'd1;

  always_comb begin
    state_next        = state;
    emit              = 1'b0;
    result.code_point = '0;
    result.status     = ST_OK;
    result.is_term    = 1'b0;
    if (state.bytes_left == 2'd0) begin
      if (byte_in[7] == 1'b0) begin
        emit              = 1'b1;
        result.code_point = {{(CP_W-BYTE_W){1'b0}}, byte_in};
        result.is_term    = (byte_in == '0);
      end else if (byte_in[7:5] == 3'b110) begin
        state_next.bytes_left  = 2'd1;
        state_next.accumulator = {{(CP_W-5){1'b0}}, byte_in[4:0]};
        state_next.bad_cont    = 1'b0;
      end else if (byte_in[7:4] == 4'b1110) begin
        state_next.bytes_left  = 2'd2;
        state_next.accumulator = {{(CP_W-4){1'b0}}, byte_in[3:0]};
        state_next.bad_cont    = 1'b0;
      end else if (byte_in[7:3] == 5'b11110) begin
        state_next.bytes_left  = 2'd3;
        state_next.accumulator = {{(CP_W-3){1'b0}}, byte_in[2:0]};
        state_next.bad_cont    = 1'b0;
      end else begin
        // dropped byte, still reported
        emit          = 1'b1;
        result.status = ST_BAD_LEADER;
      end
    end else begin
      if (byte_in[7:6] == 2'b10) begin
        state_next.accumulator = {state.accumulator[CP_W-7:0], byte_in[5:0]};
      end else begin
        state_next.bad_cont = 1'b1;
      end
      state_next.bytes_left = left_dec;
      if (left_dec == 2'd0) begin
        emit = 1'b1;
        if (state_next.bad_cont) begin
          result.code_point = REPLACEMENT_CP;
          result.status     = ST_BAD_CONT;
        end else begin
          result.code_point = state_next.accumulator;
        end
        state_next.accumulator = '0;
        state_next.bad_cont    = 1'b0;
      end
    end
  end

endmodule

// ===== sv/utf8d_out_reg.sv =====
// Result register driving the master-side stream.
// Depends on utf8d_pkg.
`timescale 1ns / 1ps

module utf8d_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  utf8d_pkg::result_t result,
  output logic               out_free,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [23:0]        m_tdata,   // [20:0] code_point, [23:21] zero
  output logic [1:0]         m_tuser,   // [1:0] status
  output logic               m_tlast    // is_terminator
);
  import utf8d_pkg::*;

  result_t held;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && load) begin
      held <= result;
    end
  end

  assign m_tdata = {{(24-CP_W){1'b0}}, held.code_point};
  assign m_tuser = held.status;
  assign m_tlast = held.is_term;

endmodule

// ===== sv/utf8_stream_decoder_core.sv =====
// UTF-8 stream decoder: one byte per transfer in, one code point per sequence out.
// Path: input register, single decode step, result register.
// Throughput: one byte per cycle, stalling while a full result register waits on m_tready.
// Reset (rst, synchronous): clears both valid flags and the decoder state.
// Depends on utf8d_pkg, utf8d_step, utf8d_out_reg, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utf8_stream_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
  output logic [1:0]  m_tuser,   // [1:0] status
  output logic        m_tlast    // is_terminator
);
  import utf8d_pkg::*;

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  dec_state_t        dec_state;
  dec_state_t        dec_state_next;
  logic              step_emit;
  result_t           step_result;
  logic              out_free;
  logic              advance;

  // byte leaves the input register when its result (if any) has room
  assign advance  = in_valid && (!step_emit || out_free);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_state <= '0;
    end else if (advance) begin
      dec_state <= dec_state_next;
    end
  end

  utf8d_step u_step (
    .byte_in    (in_byte),
    .state      (dec_state),
    .state_next (dec_state_next),
    .emit       (step_emit),
    .result     (step_result)
  );

  utf8d_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && step_emit),
    .result   (step_result),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  `ASSERT_IMPL(a_acc_narrow, clk, rst, dec_state.bytes_left == 2'd3, dec_state.accumulator[CP_W-1:3] == '0, "accumulator too wide after 4-byte leader")
  `ASSERT_IMPL(a_bad_cont_cp, clk, rst, m_tvalid && m_tuser == ST_BAD_CONT, m_tdata[CP_W-1:0] == REPLACEMENT_CP, "malformed sequence without replacement")
  `ASSERT_IMPL(a_term_ok, clk, rst, m_tvalid && m_tlast, m_tdata == '0 && m_tuser == ST_OK, "terminator with nonzero data")
  `ASSERT_NEXT(a_emit_lands, clk, rst, advance && step_emit, m_tvalid, "result lost on transfer")

endmodule
